### rtl/glq_pkg.sv
`default_nettype none

package glq_pkg;

  // stream payload widths
  localparam int S_DATA_W = 88;
  localparam int M_DATA_W = 112;
  localparam int CMD_W    = 3;

  // command codes carried on the input tuser
  localparam logic [CMD_W-1:0] CMD_LOAD_GLYPH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_KERN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHAR       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // record kinds carried on the output tuser
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_LINE_GAP     = 2'd0;
  localparam logic [1:0] REG_CELL_WIDTH   = 2'd1;
  localparam logic [1:0] REG_CELL_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_VERTEX_COLOR = 2'd3;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [31:0] COLOR_RESET  = 32'hFFFF_FFFF;

  // one glyph metrics entry
  typedef struct packed {
    logic signed [7:0] advance;
    logic signed [7:0] top;
    logic signed [7:0] left;
    logic [7:0]        height;
    logic [7:0]        width;
  } glyph_t;

  // quad request from the layout stage to the record emitter
  typedef struct packed {
    logic signed [16:0] su0;
    logic signed [17:0] sv0;
    logic [15:0]        u0;
    logic [15:0]        v0;
    logic [7:0]         width;
    logic [7:0]         height;
    logic [15:0]        i0;
  } emit_req_t;

  // clamp to the signed 16 bit range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/glq_tables.sv
`default_nettype none

module glq_tables #(
  parameter int GLYPH_COUNT = 96,
  parameter int GAW         = 7,
  parameter int KAW         = 14
) (
  input  wire logic               clk,
  input  wire logic               glyph_we,
  input  wire logic [GAW-1:0]     glyph_waddr,
  input  wire glq_pkg::glyph_t    glyph_wdata,
  input  wire logic               kern_we,
  input  wire logic [KAW-1:0]     kern_waddr,
  input  wire logic [7:0]         kern_wdata,
  input  wire logic               rd_en,
  input  wire logic [GAW-1:0]     glyph_raddr,
  input  wire logic [GAW-1:0]     prev_raddr,
  input  wire logic [KAW-1:0]     kern_raddr,
  output glq_pkg::glyph_t         glyph_rdata,
  output logic signed [7:0]       prev_advance,
  output logic signed [7:0]       kern_rdata
);

  glq_pkg::glyph_t glyph_mem [GLYPH_COUNT];
  logic [7:0]      kern_mem  [GLYPH_COUNT*GLYPH_COUNT];

  // glyph metrics: one write port, two read ports (current and previous glyph)
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= glyph_wdata;
    end
    if (rd_en) begin
      glyph_rdata  <= glyph_mem[glyph_raddr];
      prev_advance <= glyph_mem[prev_raddr].advance;
    end
  end

  // kerning pairs: one write port, one read port
  always_ff @(posedge clk) begin
    if (kern_we) begin
      kern_mem[kern_waddr] <= kern_wdata;
    end
    if (rd_en) begin
      kern_rdata <= kern_mem[kern_raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/glq_emit.sv
`default_nettype none

module glq_emit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  input  wire glq_pkg::emit_req_t              req,
  output logic                                 req_ready,
  input  wire logic [31:0]                     color,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // vertex_number, screen_x, screen_y, atlas_u, atlas_v, color (from bit 0 up)
  output logic [glq_pkg::M_DATA_W-1:0]         m_axis_tdata,
  // kind
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam logic [3:0] STEP_V0 = 4'd0;
  localparam logic [3:0] STEP_V1 = 4'd1;
  localparam logic [3:0] STEP_V2 = 4'd2;
  localparam logic [3:0] STEP_V3 = 4'd3;
  localparam logic [3:0] STEP_I0 = 4'd4;
  localparam logic [3:0] STEP_I1 = 4'd5;
  localparam logic [3:0] STEP_I2 = 4'd6;
  localparam logic [3:0] STEP_I3 = 4'd7;
  localparam logic [3:0] STEP_I4 = 4'd8;
  localparam logic [3:0] STEP_I5 = 4'd9;

  logic               busy;
  logic [3:0]         step;
  glq_pkg::emit_req_t quad;

  logic               finish;
  logic               use_x1;
  logic               use_y1;
  logic               is_index;
  logic [1:0]         offset;
  logic signed [17:0] su1;
  logic signed [17:0] sv1;
  logic [15:0]        u1;
  logic [15:0]        v1;
  logic [15:0]        sx;
  logic [15:0]        sy;
  logic [15:0]        au;
  logic [15:0]        av;
  logic [15:0]        num;

  assign finish    = busy && m_axis_tready && (step == STEP_I5);
  assign req_ready = !busy || finish;

  // step counter over the ten records of one quad
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_V0;
    end else if (req_valid && req_ready) begin
      busy <= 1'b1;
      step <= STEP_V0;
    end else if (finish) begin
      busy <= 1'b0;
    end else if (busy && m_axis_tready) begin
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      quad <= req;
    end
  end

  // corner selection and index pattern per step
  always_comb begin
    use_x1   = 1'b0;
    use_y1   = 1'b0;
    is_index = 1'b1;
    offset   = 2'd0;
    case (step)
      STEP_V0: begin
        is_index = 1'b0;
        offset   = 2'd0;
      end
      STEP_V1: begin
        is_index = 1'b0;
        use_y1   = 1'b1;
        offset   = 2'd1;
      end
      STEP_V2: begin
        is_index = 1'b0;
        use_x1   = 1'b1;
        use_y1   = 1'b1;
        offset   = 2'd2;
      end
      STEP_V3: begin
        is_index = 1'b0;
        use_x1   = 1'b1;
        offset   = 2'd3;
      end
      STEP_I0: offset = 2'd2;
      STEP_I1: offset = 2'd1;
      STEP_I2: offset = 2'd0;
      STEP_I3: offset = 2'd3;
      STEP_I4: offset = 2'd2;
      STEP_I5: offset = 2'd0;
      default: offset = 2'd0;
    endcase
  end

  // far corners and saturation
  always_comb begin
    su1 = 18'(quad.su0) + 18'(quad.width);
    sv1 = quad.sv0 + 18'(quad.height);
    u1  = quad.u0 + 16'(quad.width);
    v1  = quad.v0 + 16'(quad.height);
    sx  = glq_pkg::sat16(use_x1 ? su1 : 18'(quad.su0));
    sy  = glq_pkg::sat16(use_y1 ? sv1 : quad.sv0);
    au  = use_x1 ? u1 : quad.u0;
    av  = use_y1 ? v1 : quad.v0;
    num = quad.i0 + 16'(offset);
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tuser  = is_index ? glq_pkg::KIND_INDEX : glq_pkg::KIND_VERTEX;
  assign m_axis_tlast  = (step == STEP_I5);
  assign m_axis_tdata  = is_index ? {96'd0, num} : {color, av, au, sy, sx, num};

endmodule

`default_nettype wire

### rtl/glyph_quad_layout_top.sv
`default_nettype none
// a request is registered in the layout stage, then a character's quad in the emitter,
//   which puts its first record on the output; each quad is ten records on the output channel;
//   loads, begin, newline and clear go at one per cycle unless a character is held in layout
// the next request is taken while a quad is still draining from the record emitter
// reset (rst, synchronous): pen, line state, vertex count, pipeline cleared, registers reset;
//   glyph and kerning memories keep their contents and must be loaded before use

module glyph_quad_layout_top #(
  parameter int FIRST_CODE    = 32,
  parameter int GLYPH_COUNT   = 96,
  parameter int ATLAS_COLUMNS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // char_code, second_code, glyph_width, glyph_height, bearing_left, bearing_top,
  // advance_or_kern, start_x, start_y (from bit 0 up)
  input  wire logic [glq_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  wire logic [glq_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // vertex_number, screen_x, screen_y, atlas_u, atlas_v, color (from bit 0 up)
  output logic [glq_pkg::M_DATA_W-1:0]         m_axis_tdata,
  // kind
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [3:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int GAW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int KAW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT * GLYPH_COUNT) : 1;
  localparam logic [9:0]     FIRST10 = 10'(FIRST_CODE);
  localparam logic [9:0]     COUNT10 = 10'(GLYPH_COUNT);
  localparam logic [KAW-1:0] COUNT_K = KAW'(GLYPH_COUNT);

  // configuration registers
  logic [7:0]  line_gap;
  logic [7:0]  cell_width;
  logic [7:0]  cell_height;
  logic [31:0] vertex_color;

  // layout state
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic signed [15:0] line_start_x;
  logic               have_previous;
  logic [GAW-1:0]     previous_glyph;
  logic [15:0]        vertex_count;

  // input fields
  logic [2:0]         in_cmd;
  logic [7:0]         in_char;
  logic [7:0]         in_second;
  logic signed [15:0] in_start_x;
  logic signed [15:0] in_start_y;
  glq_pkg::glyph_t    in_glyph;
  logic               accept;

  logic [9:0]         diff1;
  logic [9:0]         diff2;
  logic               ok1;
  logic               ok2;
  logic [GAW-1:0]     idx1;
  logic [GAW-1:0]     idx2;
  logic [GAW-1:0]     prev_fwd;

  // layout stage
  logic               s1_valid;
  logic [2:0]         s1_cmd;
  logic               s1_ok;
  logic               s1_newline;
  logic [GAW-1:0]     s1_idx;
  logic signed [15:0] s1_start_x;
  logic signed [15:0] s1_start_y;
  logic               s1_glyph_char;
  logic               s1_go;

  glq_pkg::glyph_t    g_rd;
  logic signed [7:0]  prev_adv;
  logic signed [7:0]  kern_rd;

  logic [GAW-1:0]     col_tab [GLYPH_COUNT];
  logic [GAW-1:0]     row_tab [GLYPH_COUNT];

  logic signed [17:0] pen_sum;
  logic signed [15:0] pen_x_next;
  logic signed [15:0] newline_y;
  glq_pkg::emit_req_t req;
  logic               req_ready;

  // ---------------- configuration port ----------------

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_gap     <= 8'd0;
      cell_width   <= 8'd0;
      cell_height  <= 8'd0;
      vertex_color <= glq_pkg::COLOR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        glq_pkg::REG_LINE_GAP:     line_gap     <= pwdata[7:0];
        glq_pkg::REG_CELL_WIDTH:   cell_width   <= pwdata[7:0];
        glq_pkg::REG_CELL_HEIGHT:  cell_height  <= pwdata[7:0];
        glq_pkg::REG_VERTEX_COLOR: vertex_color <= pwdata;
        default:                   line_gap     <= line_gap;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      glq_pkg::REG_LINE_GAP:     prdata = {24'd0, line_gap};
      glq_pkg::REG_CELL_WIDTH:   prdata = {24'd0, cell_width};
      glq_pkg::REG_CELL_HEIGHT:  prdata = {24'd0, cell_height};
      glq_pkg::REG_VERTEX_COLOR: prdata = vertex_color;
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------- request decode ----------------

  assign in_cmd           = s_axis_tuser;
  assign in_char          = s_axis_tdata[7:0];
  assign in_second        = s_axis_tdata[15:8];
  assign in_glyph.width   = s_axis_tdata[23:16];
  assign in_glyph.height  = s_axis_tdata[31:24];
  assign in_glyph.left    = s_axis_tdata[39:32];
  assign in_glyph.top     = s_axis_tdata[47:40];
  assign in_glyph.advance = s_axis_tdata[55:48];
  assign in_start_x       = s_axis_tdata[71:56];
  assign in_start_y       = s_axis_tdata[87:72];

  // table range check of both codes
  assign diff1 = {2'b00, in_char} - FIRST10;
  assign diff2 = {2'b00, in_second} - FIRST10;
  assign ok1   = ({2'b00, in_char} >= FIRST10) && (diff1 < COUNT10);
  assign ok2   = ({2'b00, in_second} >= FIRST10) && (diff2 < COUNT10);
  assign idx1  = diff1[GAW-1:0];
  assign idx2  = diff2[GAW-1:0];

  assign s_axis_tready = !s1_valid || s1_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // previous glyph forwarded from a character still in the layout stage
  assign s1_glyph_char = (s1_cmd == glq_pkg::CMD_CHAR) && !s1_newline && s1_ok;
  assign prev_fwd      = (s1_valid && s1_glyph_char) ? s1_idx : previous_glyph;

  glq_tables #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GAW         (GAW),
    .KAW         (KAW)
  ) u_tables (
    .clk          (clk),
    .glyph_we     (accept && (in_cmd == glq_pkg::CMD_LOAD_GLYPH) && ok1),
    .glyph_waddr  (idx1),
    .glyph_wdata  (in_glyph),
    .kern_we      (accept && (in_cmd == glq_pkg::CMD_LOAD_KERN) && ok1 && ok2),
    .kern_waddr   (KAW'(idx1) * COUNT_K + KAW'(idx2)),
    .kern_wdata   (in_glyph.advance),
    .rd_en        (accept),
    .glyph_raddr  (idx1),
    .prev_raddr   (prev_fwd),
    .kern_raddr   (KAW'(prev_fwd) * COUNT_K + KAW'(idx1)),
    .glyph_rdata  (g_rd),
    .prev_advance (prev_adv),
    .kern_rdata   (kern_rd)
  );

  // ---------------- layout stage ----------------

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= in_cmd;
      s1_ok      <= ok1;
      s1_newline <= (in_char == glq_pkg::NEWLINE_CODE);
      s1_idx     <= idx1;
      s1_start_x <= in_start_x;
      s1_start_y <= in_start_y;
    end
  end

  assign s1_go = s1_valid && (!s1_glyph_char || req_ready);

  // atlas cell column and row of each glyph
  for (genvar g = 0; g < GLYPH_COUNT; g++) begin : g_cell
    assign col_tab[g] = GAW'(g % ATLAS_COLUMNS);
    assign row_tab[g] = GAW'(g / ATLAS_COLUMNS);
  end

  // pen advance with kerning, newline drop, quad origin
  always_comb begin
    pen_sum    = 18'(pen_x) + 18'(prev_adv) + 18'(kern_rd);
    pen_x_next = have_previous ? glq_pkg::sat16(pen_sum) : pen_x;
    newline_y  = glq_pkg::sat16(18'(pen_y) + 18'(cell_height) + 18'(line_gap));
    req.su0    = 17'(pen_x_next) + 17'(g_rd.left);
    req.sv0    = 18'(pen_y) + 18'(cell_height) - 18'(g_rd.top);
    req.u0     = 16'(col_tab[s1_idx]) * 16'(cell_width);
    req.v0     = 16'(row_tab[s1_idx]) * 16'(cell_height);
    req.width  = g_rd.width;
    req.height = g_rd.height;
    req.i0     = vertex_count;
  end

  // state update when a request leaves the layout stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x          <= 16'sd0;
      pen_y          <= 16'sd0;
      line_start_x   <= 16'sd0;
      have_previous  <= 1'b0;
      previous_glyph <= '0;
      vertex_count   <= 16'd0;
    end else if (s1_go) begin
      case (s1_cmd)
        glq_pkg::CMD_BEGIN: begin
          pen_x         <= s1_start_x;
          pen_y         <= s1_start_y;
          line_start_x  <= s1_start_x;
          have_previous <= 1'b0;
        end
        glq_pkg::CMD_CLEAR: begin
          vertex_count <= 16'd0;
        end
        glq_pkg::CMD_CHAR: begin
          if (s1_newline) begin
            pen_x         <= line_start_x;
            pen_y         <= newline_y;
            have_previous <= 1'b0;
          end else if (s1_ok) begin
            pen_x          <= pen_x_next;
            have_previous  <= 1'b1;
            previous_glyph <= s1_idx;
            vertex_count   <= vertex_count + 16'd4;
          end
        end
        default: begin
          have_previous <= have_previous;
        end
      endcase
    end
  end

  // ---------------- record emitter ----------------

  glq_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (s1_valid && s1_glyph_char),
    .req           (req),
    .req_ready     (req_ready),
    .color         (vertex_color),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### rtl/glq_checker.sv
`default_nettype none

module glq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [glq_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input wire logic                          m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // the closing record of a quad is an index record
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == glq_pkg::KIND_INDEX)
    else $error("tlast on a vertex record");

  // index records carry no geometry or color
  a_index_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == glq_pkg::KIND_INDEX)
      |-> m_axis_tdata[glq_pkg::M_DATA_W-1:16] == '0)
    else $error("index record with nonzero payload");

  // a new quad always opens with a vertex record
  a_quad_start: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast
      |=> !m_axis_tvalid || (m_axis_tuser == glq_pkg::KIND_VERTEX))
    else $error("quad does not start with a vertex");

  // stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
          && $stable(m_axis_tlast))
    else $error("stalled record changed");

endmodule

bind glyph_quad_layout_top glq_checker u_glq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
